### hdl/pcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcb_pkg: shared definitions of the pixel convert and blend unit
// Field widths, pixel modes, word commands, register indexes and the
// configuration record passed between the register block and the datapath.
// ----------------------------------------------------------------------------
package pcb_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_IDX_W     = $clog2(PALETTE_DEPTH);

   localparam int PIXEL_W       = 32;
   localparam int CHAN_W        = 8;
   localparam int TABLE_IDX_W   = 8;
   localparam int MODE_W        = 4;

   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_MODE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_MASK_ENABLE = 1'b1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_TABLE = 1'b1;

   localparam logic [MODE_W-1:0] MODE_COPY      = 4'd0;
   localparam logic [MODE_W-1:0] MODE_SRC_BLEND = 4'd1;
   localparam logic [MODE_W-1:0] MODE_EXT_BLEND = 4'd2;
   localparam logic [MODE_W-1:0] MODE_RGB565    = 4'd3;
   localparam logic [MODE_W-1:0] MODE_RGB888    = 4'd4;
   localparam logic [MODE_W-1:0] MODE_BGR888    = 4'd5;
   localparam logic [MODE_W-1:0] MODE_ARGB1555  = 4'd6;
   localparam logic [MODE_W-1:0] MODE_PAL8      = 4'd7;
   localparam logic [MODE_W-1:0] MODE_PAL8_SWAP = 4'd8;
   localparam logic [MODE_W-1:0] MODE_PAL4      = 4'd9;

   typedef struct packed {
      logic [MODE_W-1:0] pixel_mode;
      logic              mask_enable;
   } cfg_type;

endpackage
`default_nettype wire

### hdl/pcb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcb_if: word channels of the pixel convert and blend unit
// Request channel carries pixel and palette write words, response channel
// carries the resulting ARGB8888 word; both use valid/ready.
// ----------------------------------------------------------------------------
interface pcb_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  command;
   logic [pcb_pkg::PIXEL_W-1:0]           src_pixel;
   logic [pcb_pkg::PIXEL_W-1:0]           dst_pixel;
   logic [pcb_pkg::CHAN_W-1:0]            ext_alpha;
   logic                                  mask_bit;
   logic [pcb_pkg::TABLE_IDX_W-1:0]       table_index;
   logic [pcb_pkg::PIXEL_W-1:0]           table_word;

   modport source (
      output valid, command, src_pixel, dst_pixel, ext_alpha, mask_bit,
             table_index, table_word,
      input  ready
   );
   modport sink (
      input  valid, command, src_pixel, dst_pixel, ext_alpha, mask_bit,
             table_index, table_word,
      output ready
   );
endinterface

interface pcb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pcb_pkg::PIXEL_W-1:0] out_pixel;

   modport source (
      output valid, out_pixel,
      input  ready
   );
   modport sink (
      input  valid, out_pixel,
      output ready
   );
endinterface
`default_nettype wire

### hdl/pcb_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcb_csr: configuration registers
// Holds the pixel mode and the mask enable, written through a plain port.
// ----------------------------------------------------------------------------
module pcb_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_enable,
   input  wire logic [pcb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pcb_pkg::CSR_DATA_W-1:0]  csr_data,
   output pcb_pkg::cfg_type                    cfg
);
   import pcb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_PIXEL_MODE:  cfg_in.pixel_mode  = csr_data[MODE_W-1:0];
            REG_MASK_ENABLE: cfg_in.mask_enable = csr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### hdl/pcb_palette.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcb_palette: colour lookup table
// Single write port and one registered read port; reads beyond the table
// depth return zero.
// ----------------------------------------------------------------------------
module pcb_palette (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [pcb_pkg::TABLE_IDX_W-1:0]  wr_idx,
   input  wire logic [pcb_pkg::PIXEL_W-1:0]      wr_data,
   input  wire logic                             rd_en,
   input  wire logic [pcb_pkg::TABLE_IDX_W-1:0]  rd_idx,
   output logic      [pcb_pkg::PIXEL_W-1:0]      rd_data
);
   import pcb_pkg::*;

   logic [PIXEL_W-1:0] mem [PALETTE_DEPTH];
   logic [PIXEL_W-1:0] rd_data_ff;
   logic               rd_hit_ff;
   logic               wr_hit;
   logic               rd_hit;

   assign wr_hit = 32'(wr_idx) < PALETTE_DEPTH;
   assign rd_hit = 32'(rd_idx) < PALETTE_DEPTH;

   always_ff @(posedge clock) begin
      if (wr_en && wr_hit) begin
         mem[wr_idx[PAL_IDX_W-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx[PAL_IDX_W-1:0]];
         rd_hit_ff  <= rd_hit;
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

### hdl/pcb_convert.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcb_convert: pixel format conversion and alpha blend
// Forms the ARGB8888 result of one pixel word from the registered operands.
// ----------------------------------------------------------------------------
module pcb_convert (
   input  pcb_pkg::cfg_type                  cfg,
   input  wire logic [pcb_pkg::PIXEL_W-1:0]  src_pixel,
   input  wire logic [pcb_pkg::PIXEL_W-1:0]  dst_pixel,
   input  wire logic [pcb_pkg::CHAN_W-1:0]   ext_alpha,
   input  wire logic                         mask_bit,
   input  wire logic [pcb_pkg::PIXEL_W-1:0]  pal_data,
   output logic      [pcb_pkg::PIXEL_W-1:0]  out_pixel
);
   import pcb_pkg::*;

   // floor(x / 255) for x below 65280
   function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
      logic [2*CHAN_W:0] t;
      t = {1'b0, x} + (2*CHAN_W+1)'(x[2*CHAN_W-1:CHAN_W]) + (2*CHAN_W+1)'(1);
      return t[2*CHAN_W-1:CHAN_W];
   endfunction

   function automatic logic [CHAN_W-1:0] mix(input logic [CHAN_W-1:0] s,
                                             input logic [CHAN_W-1:0] d,
                                             input logic [CHAN_W-1:0] a);
      logic [CHAN_W-1:0]   ia;
      logic [2*CHAN_W-1:0] ps;
      logic [2*CHAN_W-1:0] pd;
      logic [CHAN_W:0]     sum;
      ia  = ~a;
      ps  = {{CHAN_W{1'b0}}, s} * {{CHAN_W{1'b0}}, a};
      pd  = {{CHAN_W{1'b0}}, d} * {{CHAN_W{1'b0}}, ia};
      sum = {1'b0, div255(ps)} + {1'b0, div255(pd)};
      return sum[CHAN_W-1:0];
   endfunction

   function automatic logic [PIXEL_W-1:0] blend(input logic [PIXEL_W-1:0] s,
                                                input logic [PIXEL_W-1:0] d,
                                                input logic [CHAN_W-1:0]  a);
      logic [PIXEL_W-1:0] r;
      if (a == '1) begin
         r = s;
      end else if (a == '0) begin
         r = d;
      end else begin
         r = {8'h00, mix(s[23:16], d[23:16], a), mix(s[15:8], d[15:8], a),
              mix(s[7:0], d[7:0], a)};
      end
      return r;
   endfunction

   logic masked;

   assign masked = mask_bit && cfg.mask_enable;

   always_comb begin
      case (cfg.pixel_mode)
         MODE_SRC_BLEND: out_pixel = blend(src_pixel, dst_pixel, src_pixel[31:24]);
         MODE_EXT_BLEND: out_pixel = blend(src_pixel, dst_pixel, ext_alpha);
         MODE_RGB565:    out_pixel = {8'h00, src_pixel[15:11], 3'b000,
                                      src_pixel[10:5], 2'b00, src_pixel[4:0], 3'b000};
         MODE_RGB888:    out_pixel = {8'h00, src_pixel[23:0]};
         MODE_BGR888:    out_pixel = {8'h00, src_pixel[7:0], src_pixel[15:8],
                                      src_pixel[23:16]};
         MODE_ARGB1555:  out_pixel = {8'h00, src_pixel[14:10], 3'b000,
                                      src_pixel[9:5], 3'b000, src_pixel[4:0], 3'b000};
         MODE_PAL8,
         MODE_PAL4:      out_pixel = masked ? '0 : pal_data;
         MODE_PAL8_SWAP: out_pixel = masked ? '0 : {pal_data[31:24], pal_data[7:0],
                                                    pal_data[15:8], pal_data[23:16]};
         default:        out_pixel = src_pixel;
      endcase
   end

endmodule
`default_nettype wire

### hdl/pixel_convert_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_convert_blend: pixel unit of a blitter
// Converts or blends one pixel word per cycle into ARGB8888, unless the response
// channel stalls, and keeps the colour lookup table filled by table write words.
// ----------------------------------------------------------------------------
// an accepted pixel word passes the input stage registers and table read, then the output register that offers it
// throughput: one word per cycle unless responses stall, set by the single-port table read and output register
// table write words are written to the table on acceptance and give no result
// reset clears the mode, mask enable and pipeline valids; table contents stay
// undefined until written and need no clearing pass
module pixel_convert_blend (
   input  wire logic                            clock,
   input  wire logic                            reset,
   pcb_req_if.sink                              req_chan,
   pcb_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_write_enable,
   input  wire logic [pcb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pcb_pkg::CSR_DATA_W-1:0]  csr_data
);
   import pcb_pkg::*;

   cfg_type             cfg;
   logic                req_acc;
   logic                pix_acc;
   logic                tbl_acc;
   logic                s2_take;
   logic                s1_adv;
   logic [TABLE_IDX_W-1:0] rd_idx;
   logic [PIXEL_W-1:0]  pal_data;
   logic [PIXEL_W-1:0]  conv_pixel;

   logic                s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0]  src_ff;
   logic [PIXEL_W-1:0]  dst_ff;
   logic [CHAN_W-1:0]   ext_ff;
   logic                mask_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]  out_pixel_ff, out_pixel_in;

   pcb_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   assign s2_take       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv        = s1_valid_ff && s2_take;
   assign req_chan.ready = !s1_valid_ff || s2_take;
   assign req_acc       = req_chan.valid && req_chan.ready;
   assign pix_acc       = req_acc && (req_chan.command == CMD_PIXEL);
   assign tbl_acc       = req_acc && (req_chan.command == CMD_TABLE);

   assign rd_idx = (cfg.pixel_mode == MODE_PAL4) ?
                   {{(TABLE_IDX_W-4){1'b0}}, req_chan.src_pixel[3:0]} :
                   req_chan.src_pixel[TABLE_IDX_W-1:0];

   pcb_palette u_palette (
      .clock   (clock),
      .wr_en   (tbl_acc),
      .wr_idx  (req_chan.table_index),
      .wr_data (req_chan.table_word),
      .rd_en   (pix_acc),
      .rd_idx  (rd_idx),
      .rd_data (pal_data)
   );

   pcb_convert u_convert (
      .cfg       (cfg),
      .src_pixel (src_ff),
      .dst_pixel (dst_ff),
      .ext_alpha (ext_ff),
      .mask_bit  (mask_ff),
      .pal_data  (pal_data),
      .out_pixel (conv_pixel)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pix_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_pixel_in = out_pixel_ff;
      if (s2_take) begin
         rsp_valid_in = s1_valid_ff;
         out_pixel_in = conv_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_acc) begin
         src_ff  <= req_chan.src_pixel;
         dst_ff  <= req_chan.dst_pixel;
         ext_ff  <= req_chan.ext_alpha;
         mask_ff <= req_chan.mask_bit;
      end
      out_pixel_ff <= out_pixel_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_pixel = out_pixel_ff;

`ifndef SYNTH
   a_pixel_enters: assert property (@(posedge clock) disable iff (reset)
      pix_acc |=> s1_valid_ff)
      else $error("accepted pixel word not held in input stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_take) |=> (s1_valid_ff && $stable(src_ff)))
      else $error("stalled input stage lost its word");

   a_table_no_result: assert property (@(posedge clock) disable iff (reset)
      (tbl_acc && !s1_valid_ff) |=> !s1_valid_ff)
      else $error("table write word produced a result");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("input stage drained without a response");
`endif

endmodule
`default_nettype wire

### tb/sv/pixel_convert_blend_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_convert_blend_tb: self-checking bench of the blitter pixel unit
// Drives pixel and palette write words through the request channel with
// random idle bursts and response stalls. It steps the pixel mode and mask
// enable through every code, predicts each ARGB8888 word in the bench and
// checks every response against the oldest prediction.
// ----------------------------------------------------------------------------
module pixel_convert_blend_tb;
   import pcb_pkg::*;

   localparam int PHASE_WORDS = 57;

   typedef struct {
      logic                   command;
      logic [PIXEL_W-1:0]     src_pixel;
      logic [PIXEL_W-1:0]     dst_pixel;
      logic [CHAN_W-1:0]      ext_alpha;
      logic                   mask_bit;
      logic [TABLE_IDX_W-1:0] table_index;
      logic [PIXEL_W-1:0]     table_word;
   } pixel_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   pcb_req_if req_chan ();
   pcb_rsp_if rsp_chan ();

   pixel_word_t        pixel_words [$];
   logic [PIXEL_W-1:0] expected_pixels [$];
   logic [PIXEL_W-1:0] palette_copy [0:PALETTE_DEPTH-1];
   logic [MODE_W-1:0]  cur_mode;
   logic               cur_mask_enable;
   bit                 palette_filled [0:PALETTE_DEPTH-1];
   logic [7:0]         filled_list [$];
   bit                 idle_on = 1'b1;
   bit                 req_fired = 1'b0;
   int                 req_gap = 0;
   int                 rsp_gap = 0;
   int                 mismatches = 0;
   pixel_word_t        next_word;
   pixel_word_t        seen_word;
   logic [PIXEL_W-1:0] predicted;

   pixel_convert_blend i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [7:0] weigh_channel(input logic [7:0] s, input logic [7:0] d,
                                                input logic [7:0] a);
      int unsigned sum;
      sum = (int'(s) * int'(a)) / 255 + (int'(d) * (255 - int'(a))) / 255;
      return sum[7:0];
   endfunction

   function automatic logic [PIXEL_W-1:0] blend_pixels(input logic [PIXEL_W-1:0] s,
                                                       input logic [PIXEL_W-1:0] d,
                                                       input logic [7:0] a);
      if (a == 8'hFF)
         return s;
      if (a == 8'h00)
         return d;
      return {8'h00, weigh_channel(s[23:16], d[23:16], a), weigh_channel(s[15:8], d[15:8], a),
              weigh_channel(s[7:0], d[7:0], a)};
   endfunction

   function automatic logic [PIXEL_W-1:0] convert_pixel(input pixel_word_t w);
      logic               masked;
      logic [PIXEL_W-1:0] s;
      logic [PIXEL_W-1:0] e;
      masked = w.mask_bit && cur_mask_enable;
      s = w.src_pixel;
      case (cur_mode)
         MODE_SRC_BLEND: return blend_pixels(s, w.dst_pixel, s[31:24]);
         MODE_EXT_BLEND: return blend_pixels(s, w.dst_pixel, w.ext_alpha);
         MODE_RGB565:    return {8'h00, s[15:11], 3'b000, s[10:5], 2'b00, s[4:0], 3'b000};
         MODE_RGB888:    return {8'h00, s[23:0]};
         MODE_BGR888:    return {8'h00, s[7:0], s[15:8], s[23:16]};
         MODE_ARGB1555:  return {8'h00, s[14:10], 3'b000, s[9:5], 3'b000, s[4:0], 3'b000};
         MODE_PAL8:      return masked ? '0 : palette_copy[s[7:0]];
         MODE_PAL8_SWAP: begin
            e = palette_copy[s[7:0]];
            return masked ? '0 : {e[31:24], e[7:0], e[15:8], e[23:16]};
         end
         MODE_PAL4:      return masked ? '0 : palette_copy[s[3:0]];
         default:        return s;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fired) begin
         if (req_gap != 0) begin
            req_gap--;
            req_chan.valid <= 1'b0;
         end else if (pixel_words.size() != 0 && idle_on && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(0, 9);
            req_chan.valid <= 1'b0;
         end else if (pixel_words.size() != 0) begin
            next_word = pixel_words.pop_front();
            req_chan.command     <= next_word.command;
            req_chan.src_pixel   <= next_word.src_pixel;
            req_chan.dst_pixel   <= next_word.dst_pixel;
            req_chan.ext_alpha   <= next_word.ext_alpha;
            req_chan.mask_bit    <= next_word.mask_bit;
            req_chan.table_index <= next_word.table_index;
            req_chan.table_word  <= next_word.table_word;
            req_chan.valid       <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gap != 0) begin
         rsp_gap--;
         rsp_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_gap = $urandom_range(0, 9);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      req_fired = !reset && req_chan.valid && req_chan.ready;
      if (reset) begin
         cur_mode        = MODE_COPY;
         cur_mask_enable = 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_PIXEL_MODE:  cur_mode = csr_data[MODE_W-1:0];
               REG_MASK_ENABLE: cur_mask_enable = csr_data[0];
               default: ;
            endcase
         end
         if (req_fired) begin
            seen_word.command     = req_chan.command;
            seen_word.src_pixel   = req_chan.src_pixel;
            seen_word.dst_pixel   = req_chan.dst_pixel;
            seen_word.ext_alpha   = req_chan.ext_alpha;
            seen_word.mask_bit    = req_chan.mask_bit;
            seen_word.table_index = req_chan.table_index;
            seen_word.table_word  = req_chan.table_word;
            if (seen_word.command == CMD_TABLE)
               palette_copy[seen_word.table_index] = seen_word.table_word;
            else
               expected_pixels.push_back(convert_pixel(seen_word));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected word out_pixel %h", rsp_chan.out_pixel));
            end else begin
               predicted = expected_pixels.pop_front();
               if (rsp_chan.out_pixel !== predicted)
                  report_mismatch($sformatf("out_pixel %h, predicted %h (mode %0d)",
                                            rsp_chan.out_pixel, predicted, cur_mode));
            end
         end
      end
   end

   function automatic logic [PIXEL_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] pick_alpha();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h01;
         3:       return 8'hFE;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic queue_table_write(input logic [TABLE_IDX_W-1:0] idx,
                                    input logic [PIXEL_W-1:0] value);
      pixel_word_t w;
      w.command     = CMD_TABLE;
      w.src_pixel   = $urandom;
      w.dst_pixel   = $urandom;
      w.ext_alpha   = 8'($urandom);
      w.mask_bit    = 1'($urandom);
      w.table_index = idx;
      w.table_word  = value;
      if (!palette_filled[idx]) begin
         palette_filled[idx] = 1'b1;
         filled_list.push_back(idx);
      end
      pixel_words.push_back(w);
   endtask

   task automatic queue_pixel(input logic [MODE_W-1:0] mode, input logic [PIXEL_W-1:0] src,
                              input logic [PIXEL_W-1:0] dst);
      pixel_word_t w;
      w.command     = CMD_PIXEL;
      w.src_pixel   = src;
      w.dst_pixel   = dst;
      w.ext_alpha   = pick_alpha();
      w.mask_bit    = 1'($urandom);
      w.table_index = 8'($urandom);
      w.table_word  = $urandom;
      if (mode == MODE_SRC_BLEND)
         w.src_pixel[31:24] = pick_alpha();
      // palette lookups only ever touch entries already written
      if (mode == MODE_PAL8 || mode == MODE_PAL8_SWAP)
         w.src_pixel[7:0] = filled_list[$urandom_range(0, filled_list.size() - 1)];
      pixel_words.push_back(w);
   endtask

   task automatic drain();
      while (pixel_words.size() != 0 || req_chan.valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input logic [MODE_W-1:0] mode, input logic mask_on,
                            input bit steady);
      drain();
      idle_on = !steady && $urandom_range(0, 3) != 0;
      write_register(REG_PIXEL_MODE, mode);
      write_register(REG_MASK_ENABLE, {3'($urandom), mask_on});
      queue_pixel(mode, '1, '0);
      queue_pixel(mode, '0, '1);
      repeat (PHASE_WORDS - 2) begin
         if ($urandom_range(0, 9) == 0)
            queue_table_write(8'($urandom), pick_word());
         else
            queue_pixel(mode, pick_word(), pick_word());
      end
   endtask

   initial begin
      int m;
      req_chan.valid       = 1'b0;
      req_chan.command     = CMD_PIXEL;
      req_chan.src_pixel   = '0;
      req_chan.dst_pixel   = '0;
      req_chan.ext_alpha   = '0;
      req_chan.mask_bit    = 1'b0;
      req_chan.table_index = '0;
      req_chan.table_word  = '0;
      rsp_chan.ready       = 1'b0;
      csr_write_enable     = 1'b0;
      csr_index            = REG_PIXEL_MODE;
      csr_data             = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // low entries cover pal4, top entry and the word extremes
      for (m = 0; m < 16; m++)
         queue_table_write(8'(m), (m == 0) ? '0 : {4{8'(m * 17)}} ^ 32'h00FF_00FF);
      queue_table_write(8'hFF, '1);
      // reset configuration: copy, mask off
      queue_pixel(MODE_COPY, '1, '0);
      queue_pixel(MODE_COPY, '0, '1);
      queue_pixel(MODE_COPY, $urandom, $urandom);

      for (m = 0; m < 16; m++)
         run_phase(MODE_W'(m), 1'(m), 1'b0);
      run_phase(MODE_PAL8, 1'b0, 1'b0);
      run_phase(MODE_PAL8_SWAP, 1'b1, 1'b0);
      run_phase(MODE_PAL4, 1'b0, 1'b0);
      run_phase(MODE_SRC_BLEND, 1'b1, 1'b1);
      run_phase(MODE_EXT_BLEND, 1'b0, 1'b1);
      drain();

      if (mismatches == 0)
         $display("pixel_convert_blend_tb passed");
      else
         $display("pixel_convert_blend_tb failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("pixel_convert_blend_tb failed");
      $finish;
   end

endmodule
